// ===== design/jsu_pkg.sv =====
// Shared types, codes and character constants of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  // Escape phase codes.
  localparam logic [2:0] PH_TEXT = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_HEX1 = 3'd2;
  localparam logic [2:0] PH_HEX2 = 3'd3;
  localparam logic [2:0] PH_HEX3 = 3'd4;
  localparam logic [2:0] PH_HEX4 = 3'd5;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_DANGLE  = 3'd1;
  localparam logic [2:0] ERR_SHORT_U = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX = 3'd3;
  localparam logic [2:0] ERR_UNREPR  = 3'd4;
  localparam logic [2:0] ERR_UNSUP   = 3'd5;

  // Characters of the escape syntax.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_LN = 8'h6E;
  localparam logic [7:0] CH_LR = 8'h72;
  localparam logic [7:0] CH_LT = 8'h74;
  localparam logic [7:0] CH_LU = 8'h75;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;

  // Decoded control bytes.
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_TAB = 8'h09;

  localparam logic [3:0] HEX_TEN = 4'd10;

  // Decoder state carried from word to word.
  typedef struct packed {
    logic [2:0]  phase;
    logic [11:0] hex_acc;  // first three digits of a \u escape
    logic [2:0]  err;
  } jsu_state_t;

  // What one input word yields.
  typedef struct packed {
    logic       emit;        // a result goes out for this word
    logic       char_valid;
    logic [7:0] out_char;
    logic [2:0] err;
  } jsu_result_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    priority if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      return {1'b1, d[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA;
      return {1'b1, d[3:0] + HEX_TEN};
    end else if (c >= CH_LA && c <= (CH_LA + 8'd5)) begin
      d = c - CH_LA;
      return {1'b1, d[3:0] + HEX_TEN};
    end else begin
      return 5'd0;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/jsu_in_if.sv =====
// Input channel: one raw byte of the escaped string per word.
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       is_last;

  modport source (output valid, output in_char, output is_last, input ready);
  modport sink   (input valid, input in_char, input is_last, output ready);
endinterface

`default_nettype wire

// ===== design/jsu_out_if.sv =====
// Output channel: one decoded result per word.
`default_nettype none

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        end_of_string;
  logic [2:0]  error_code;
  logic [15:0] out_length;

  modport source (output valid, output out_char, output char_valid, output end_of_string,
                  output error_code, output out_length, input ready);
  modport sink   (input valid, input out_char, input char_valid, input end_of_string,
                  input error_code, input out_length, output ready);
endinterface

`default_nettype wire

// ===== design/jsu_decode.sv =====
// Escape decoder: next state and result for one input byte.
`default_nettype none

module jsu_decode (
  input  jsu_pkg::jsu_state_t  state_i,
  input  logic [7:0]           char_i,
  input  logic                 last_i,
  output jsu_pkg::jsu_state_t  state_o,
  output jsu_pkg::jsu_result_t result_o
);

  logic [4:0]  hex;
  logic [15:0] acc_full;
  logic [2:0]  err;
  logic        cvalid;
  logic [7:0]  ch;
  logic [2:0]  phase_d;
  logic [11:0] acc_d;

  assign hex      = jsu_pkg::hex_digit(char_i);
  assign acc_full = {state_i.hex_acc, hex[3:0]};

  always_comb begin
    err     = jsu_pkg::ERR_NONE;
    cvalid  = 1'b0;
    ch      = 8'h00;
    phase_d = jsu_pkg::PH_TEXT;
    acc_d   = state_i.hex_acc;

    unique case (state_i.phase)
      jsu_pkg::PH_ESC: begin
        cvalid = 1'b1;
        unique case (char_i)
          jsu_pkg::CH_QUOTE:  ch = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_BSLASH: ch = jsu_pkg::CH_BSLASH;
          jsu_pkg::CH_LB:     ch = jsu_pkg::CODE_BS;
          jsu_pkg::CH_LF:     ch = jsu_pkg::CODE_FF;
          jsu_pkg::CH_LN:     ch = jsu_pkg::CODE_LF;
          jsu_pkg::CH_LR:     ch = jsu_pkg::CODE_CR;
          jsu_pkg::CH_LT:     ch = jsu_pkg::CODE_TAB;
          jsu_pkg::CH_LU: begin
            cvalid = 1'b0;
            if (last_i) begin
              err = jsu_pkg::ERR_SHORT_U;
            end else begin
              phase_d = jsu_pkg::PH_HEX1;
              acc_d   = 12'h000;
            end
          end
          default: begin
            cvalid = 1'b0;
            err    = jsu_pkg::ERR_UNSUP;
          end
        endcase
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4: begin
        if (!hex[4]) begin
          err = jsu_pkg::ERR_BAD_HEX;
        end else if (state_i.phase == jsu_pkg::PH_HEX4) begin
          // The high byte of the code point must be zero.
          if (acc_full[15:8] != 8'h00) begin
            err = jsu_pkg::ERR_UNREPR;
          end else begin
            ch     = acc_full[7:0];
            cvalid = 1'b1;
          end
          acc_d = 12'h000;
        end else if (last_i) begin
          err = jsu_pkg::ERR_SHORT_U;
        end else begin
          acc_d   = acc_full[11:0];
          phase_d = state_i.phase + 3'd1;
        end
      end
      default: begin
        if (char_i == jsu_pkg::CH_BSLASH) begin
          if (last_i) err = jsu_pkg::ERR_DANGLE;
          else phase_d = jsu_pkg::PH_ESC;
        end else begin
          ch     = char_i;
          cvalid = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    result_o.emit       = (state_i.err == jsu_pkg::ERR_NONE);
    result_o.char_valid = cvalid;
    result_o.out_char   = ch;
    result_o.err        = err;

    if (last_i) begin
      state_o = '0;
    end else if (state_i.err != jsu_pkg::ERR_NONE) begin
      state_o = state_i;
    end else if (err != jsu_pkg::ERR_NONE) begin
      state_o.phase   = jsu_pkg::PH_TEXT;
      state_o.hex_acc = 12'h000;
      state_o.err     = err;
    end else begin
      state_o.phase   = phase_d;
      state_o.hex_acc = acc_d;
      state_o.err     = jsu_pkg::ERR_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== design/json_string_unescaper.sv =====
// Top level of the JSON string unescaper.
//
// Usage: the body of a JSON string enters on in_i one byte per word, with
// is_last set on its final byte. Each accepted byte yields one word on out_o:
// the decoded byte with char_valid, or char_valid low while an escape is still
// being collected, or an error code. Once an error is reported, the remaining
// bytes of that string yield no word; the byte with is_last resets the decoder
// for the next string. out_length carries the saturating count of decoded
// bytes so far, final on the word with end_of_string.
// A word is registered and shown on out_o in the cycle after its byte is accepted,
// and one byte is taken every cycle while the receiver keeps up: the decoder is a
// single combinational pass into the output register. The input is ready whenever
// that register is empty or being read in the same cycle, so a stalled receiver
// holds its word and stops the input only after one word is waiting. Reset empties
// the output register and puts the decoder in plain text with no error and a zero count.
`default_nettype none

module json_string_unescaper #(
  parameter int COUNT_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  jsu_in_if.sink         in_i,
  jsu_out_if.source      out_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  jsu_pkg::jsu_state_t  state_q, state_d;
  jsu_pkg::jsu_result_t res;
  logic [COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic [31:0]           count_ext;
  logic                  in_fire;

  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic        char_valid_q;
  logic        eos_q;
  logic [2:0]  err_q;
  logic [15:0] length_q;

  jsu_decode u_decode (
    .state_i  (state_q),
    .char_i   (in_i.in_char),
    .last_i   (in_i.is_last),
    .state_o  (state_d),
    .result_o (res)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign count_inc = (res.char_valid && count_q != CountMax) ?
                     count_q + COUNT_BITS'(1) : count_q;
  assign count_ext = 32'(count_inc);

  always_comb begin
    if (in_i.is_last) count_d = '0;
    else if (!res.emit) count_d = count_q;
    else count_d = count_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        count_q     <= count_d;
        out_valid_q <= res.emit;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res.emit) begin
      out_char_q   <= res.out_char;
      char_valid_q <= res.char_valid;
      eos_q        <= in_i.is_last;
      err_q        <= res.err;
      length_q     <= count_ext[15:0];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_char      = out_char_q;
  assign out_o.char_valid    = char_valid_q;
  assign out_o.end_of_string = eos_q;
  assign out_o.error_code    = err_q;
  assign out_o.out_length    = length_q;

endmodule

`default_nettype wire

// ===== design/jsu_checker.sv =====
// Port-level checks of the JSON string unescaper, bound to the top level.
`default_nettype none

module jsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_char_i,
  input logic        char_valid_i,
  input logic [2:0]  error_code_i
);

  // A waiting word is kept until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // The input stays open while the output register is empty.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output register");

  // An error word carries no decoded byte.
  a_err_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i != jsu_pkg::ERR_NONE |-> !char_valid_i && out_char_i == 8'h00)
    else $error("error word carries a byte");

  // A word appears only in the cycle after an accepted byte.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("output word without an accepted byte");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_char_i   (out_o.out_char),
  .char_valid_i (out_o.char_valid),
  .error_code_i (out_o.error_code)
);

`default_nettype wire
